[sv/multichannel_pulse_width_capture_macros.svh]
// assertion macros for the pulse width capture block
`ifndef MULTICHANNEL_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define MULTICHANNEL_PULSE_WIDTH_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS
`define MPWC_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");
`define MPWC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MPWC_ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define MPWC_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

[sv/mpwc_pkg.sv]
// shared types and constants for the pulse width capture block
`default_nettype none
package mpwc_pkg;

  localparam int MPWC_MAX_CH   = 8;
  localparam int MPWC_CHANNELS = 8;
  localparam int MPWC_TS_W     = 16;
  localparam int MPWC_CH_W     = 3;
  localparam int MPWC_ADDR_W   = 3;

  typedef enum logic {
    REG_IN_MASK     = 1'b0,
    REG_TIMER_LIMIT = 1'b1
  } mpwc_reg_t;

  // completed pulses of one event, one bit and one width per channel
  typedef struct packed {
    logic [MPWC_MAX_CH-1:0]                done;
    logic [MPWC_MAX_CH-1:0][MPWC_TS_W-1:0] width;
  } mpwc_batch_t;

endpackage
`default_nettype wire

[sv/mpwc_if.sv]
// event and result channel interfaces
`default_nettype none
interface mpwc_in_if import mpwc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [MPWC_TS_W-1:0] timestamp;
  logic [7:0]           pin_flags;

  modport source (output valid, timestamp, pin_flags, input ready);
  modport sink   (input valid, timestamp, pin_flags, output ready);
endinterface

interface mpwc_out_if import mpwc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [MPWC_CH_W-1:0] channel;
  logic [MPWC_TS_W-1:0] width;
  logic                 last;

  modport source (output valid, channel, width, last, input ready);
  modport sink   (input valid, channel, width, last, output ready);
endinterface
`default_nettype wire

[sv/mpwc_capture.sv]
// per-channel edge state and high-time computation
`default_nettype none
module mpwc_capture import mpwc_pkg::*; #(
  parameter int CHANNELS = MPWC_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [MPWC_TS_W-1:0] timestamp,
  input  logic [7:0]           pin_flags,
  input  logic [7:0]           in_mask,
  input  logic [MPWC_TS_W-1:0] timer_limit,
  output mpwc_batch_t          batch
);

  logic [CHANNELS-1:0][MPWC_TS_W-1:0] rise_time;
  logic [CHANNELS-1:0]                await_fall;
  logic [CHANNELS-1:0]                hit;

  always_comb begin
    batch = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit[c] = pin_flags[c] & in_mask[c];
      batch.done[c] = hit[c] & await_fall[c];
      // timer wrapped: limit - rise + now, modulo 2^16
      if (rise_time[c] > timestamp) begin
        batch.width[c] = timer_limit - rise_time[c] + timestamp;
      end else begin
        batch.width[c] = timestamp - rise_time[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_fall <= '0;
      rise_time  <= '0;
    end else if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (hit[c]) begin
          if (!await_fall[c]) begin
            rise_time[c] <= timestamp;
          end
          await_fall[c] <= ~await_fall[c];
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/multichannel_pulse_width_capture.sv]
// top level: eight-channel pulse width capture with apb configuration
// an accepted event loads the batch mask, whose pulses drain through the result register
// throughput: one result per cycle unless res.ready stalls the output; a new event is
// taken once the single result register drains the per-event batch
// reset: synchronous, clears edge state, batch, output valid and sets timer_limit to 65535
`default_nettype none
`include "multichannel_pulse_width_capture_macros.svh"
module multichannel_pulse_width_capture import mpwc_pkg::*; #(
  parameter int CHANNELS = MPWC_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  mpwc_in_if.sink                ev,
  mpwc_out_if.source             res,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [MPWC_ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0]           in_mask;
  logic [MPWC_TS_W-1:0] timer_limit;
  mpwc_reg_t            reg_sel;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = mpwc_reg_t'(paddr[2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_sel)
      REG_IN_MASK:     prdata = {24'd0, in_mask};
      REG_TIMER_LIMIT: prdata = {16'd0, timer_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_mask     <= '0;
      timer_limit <= '1;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_IN_MASK:     in_mask     <= pwdata[7:0];
        REG_TIMER_LIMIT: timer_limit <= pwdata[MPWC_TS_W-1:0];
        default:         ;
      endcase
    end
  end

  logic        accept;
  mpwc_batch_t cap_batch;

  mpwc_capture #(.CHANNELS(CHANNELS)) u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .timestamp   (ev.timestamp),
    .pin_flags   (ev.pin_flags),
    .in_mask     (in_mask),
    .timer_limit (timer_limit),
    .batch       (cap_batch)
  );

  // batch of finished pulses waiting for the result register
  logic [MPWC_MAX_CH-1:0]                batch_mask;
  logic [MPWC_MAX_CH-1:0]                batch_mask_next;
  logic [MPWC_MAX_CH-1:0][MPWC_TS_W-1:0] batch_width;
  logic [MPWC_MAX_CH-1:0]                lowest;
  logic [MPWC_MAX_CH-1:0]                rest;
  logic [MPWC_CH_W-1:0]                  pick;
  logic                                  out_free;
  logic                                  pop;

  assign out_free = ~res.valid | res.ready;
  assign pop      = out_free & (|batch_mask);
  assign lowest   = batch_mask & (~batch_mask + MPWC_MAX_CH'(1));
  assign rest     = batch_mask & ~lowest;
  assign ev.ready = ((pop ? rest : batch_mask) == '0);
  assign accept   = ev.valid & ev.ready;

  always_comb begin
    pick = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (batch_mask[i]) begin
        pick = MPWC_CH_W'(i);
      end
    end
  end

  always_comb begin
    if (accept) begin
      batch_mask_next = cap_batch.done;
    end else if (pop) begin
      batch_mask_next = rest;
    end else begin
      batch_mask_next = batch_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_mask <= '0;
      res.valid  <= 1'b0;
    end else begin
      batch_mask <= batch_mask_next;
      if (pop) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      batch_width <= cap_batch.width;
    end
    if (pop) begin
      res.channel <= pick;
      res.width   <= batch_width[pick];
      res.last    <= (rest == '0);
    end
  end

  `MPWC_ASSERT_IMPLY(a_stall_only_when_busy, clk, rst, !ev.ready, batch_mask != '0)
  `MPWC_ASSERT_NEXT(a_pop_fills_output, clk, rst, pop, res.valid)
  `MPWC_ASSERT_NEXT(a_batch_loaded, clk, rst, accept, batch_mask == $past(cap_batch.done))

endmodule
`default_nettype wire
